[rtl/core/assert_macros.svh]
// Assertion macros shared by the soft power switch RTL.
// Depends on nothing; the bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define SPSW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define SPSW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SPSW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define SPSW_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/spsw_pkg.sv]
// Types, codes and reset constants of the soft power switch.
// No dependencies; used by every module of the block.
package spsw_pkg;

   localparam int unsigned INACT_W  = 24;
   localparam int unsigned CFG_W    = 16;
   localparam int unsigned HELD_W   = 17;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [HELD_W-1:0] HELD_MAX = {HELD_W{1'b1}};

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_PUSH_TO_START  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_OFF_MS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INACTIVE_OFF_S = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_ON_DELAY  = 2'd3;

   // Register reset values.
   localparam logic             RST_PUSH_TO_START  = 1'b0;
   localparam logic [CFG_W-1:0] RST_PRESS_OFF_MS   = 16'd2000;
   localparam logic [CFG_W-1:0] RST_INACTIVE_OFF_S = 16'd0;
   localparam logic [CFG_W-1:0] RST_TURN_ON_DELAY  = 16'd500;

   typedef enum logic [2:0] {
      MODE_BOOT  = 3'd0,
      MODE_DELAY = 3'd1,
      MODE_WAIT  = 3'd2,
      MODE_ON    = 3'd3,
      MODE_SHUT  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      LED_OFF  = 2'd0,
      LED_DIM  = 2'd1,
      LED_FULL = 2'd2
   } led_type;

   typedef struct packed {
      logic               button_pressed;
      logic [INACT_W-1:0] inactive_time_q8;
   } item_type;

   typedef struct packed {
      logic             power_hold;
      led_type          led_level;
      mode_type         mode_code;
   } result_type;

   typedef struct packed {
      logic             push_to_start;
      logic [CFG_W-1:0] press_off_ms;
      logic [CFG_W-1:0] inactive_off_s;
      logic [CFG_W-1:0] turn_on_delay_ticks;
   } cfg_type;

endpackage

[rtl/core/spsw_in_stage.sv]
// Input register of the soft power switch: holds one tick item.
// Depends on spsw_pkg.
module spsw_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  spsw_pkg::item_type  req_item,
   input  logic                down_free,
   output logic                item_valid,
   output spsw_pkg::item_type  item
);

   logic               valid_ff;
   logic               valid_in;
   logic               take;
   spsw_pkg::item_type item_ff;

   // The held item leaves when the result side can take it this cycle.
   assign take      = valid_ff && down_free;
   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[rtl/core/spsw_fsm.sv]
// Soft power latch state machine with held-time counter and delay countdown.
// Depends on spsw_pkg and assert_macros.svh.
`include "assert_macros.svh"
module spsw_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  spsw_pkg::item_type   item,
   input  spsw_pkg::cfg_type    cfg,
   output spsw_pkg::result_type result
);

   spsw_pkg::mode_type          mode_ff, mode_in;
   logic [spsw_pkg::HELD_W-1:0] held_ff, held_in;
   logic [spsw_pkg::CFG_W-1:0]  delay_ff, delay_in;
   logic                        hold_ff, hold_in;
   spsw_pkg::led_type           led_ff, led_in;

   logic                        over_press;
   logic                        over_inact;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= spsw_pkg::MODE_BOOT;
         held_ff  <= '0;
         delay_ff <= '0;
         hold_ff  <= 1'b0;
         led_ff   <= spsw_pkg::LED_OFF;
      end else if (advance) begin
         mode_ff  <= mode_in;
         held_ff  <= held_in;
         delay_ff <= delay_in;
         hold_ff  <= hold_in;
         led_ff   <= led_in;
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      held_in    = held_ff;
      delay_in   = delay_ff;
      hold_in    = hold_ff;
      led_in     = led_ff;
      over_press = 1'b0;
      over_inact = 1'b0;
      case (mode_ff)
         spsw_pkg::MODE_BOOT: begin
            led_in = spsw_pkg::LED_DIM;
            if (cfg.push_to_start || item.button_pressed) begin
               mode_in  = spsw_pkg::MODE_DELAY;
               delay_in = cfg.turn_on_delay_ticks;
            end else begin
               mode_in = spsw_pkg::MODE_SHUT;
            end
         end
         spsw_pkg::MODE_DELAY: begin
            if (delay_ff != '0) begin
               delay_in = delay_ff - 1'b1;
            end else begin
               mode_in = spsw_pkg::MODE_WAIT;
            end
         end
         spsw_pkg::MODE_WAIT: begin
            hold_in = 1'b1;
            if (!item.button_pressed) begin
               mode_in = spsw_pkg::MODE_ON;
            end
         end
         spsw_pkg::MODE_ON: begin
            if (item.button_pressed) begin
               if (held_ff != spsw_pkg::HELD_MAX) begin
                  held_in = held_ff + 1'b1;
               end
               led_in = spsw_pkg::LED_FULL;
            end else begin
               held_in = '0;
               led_in  = spsw_pkg::LED_DIM;
            end
            // The hold compare uses the count after this tick.
            over_press = held_in > {1'b0, cfg.press_off_ms};
            over_inact = item.inactive_time_q8 > {cfg.inactive_off_s, 8'h00};
            if ((cfg.inactive_off_s != '0) && (over_press || over_inact)) begin
               mode_in = spsw_pkg::MODE_SHUT;
            end
         end
         spsw_pkg::MODE_SHUT: begin
            led_in  = spsw_pkg::LED_OFF;
            hold_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign result.power_hold = hold_in;
   assign result.led_level  = led_in;
   assign result.mode_code  = mode_in;

   `SPSW_ASSERT_NEXT(a_shut_final, clock, reset, mode_ff == spsw_pkg::MODE_SHUT, mode_ff == spsw_pkg::MODE_SHUT, "shut down left")
   `SPSW_ASSERT_IMPLY(a_no_hold_early, clock, reset, mode_ff == spsw_pkg::MODE_BOOT || mode_ff == spsw_pkg::MODE_DELAY, !hold_ff, "supply held before wait release")
   `SPSW_ASSERT_IMPLY(a_hold_when_on, clock, reset, mode_ff == spsw_pkg::MODE_ON, hold_ff, "supply not held while on")
   `SPSW_ASSERT_IMPLY(a_held_only_on, clock, reset, held_ff != '0, mode_ff == spsw_pkg::MODE_ON || mode_ff == spsw_pkg::MODE_SHUT, "held count outside on")

endmodule

[rtl/core/spsw_out_stage.sv]
// Result register of the soft power switch with valid/ready output.
// Depends on spsw_pkg.
module spsw_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  spsw_pkg::result_type result,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output spsw_pkg::result_type rsp_result
);

   logic                 valid_ff;
   logic                 valid_in;
   spsw_pkg::result_type result_ff;

   // A new result may be loaded when the register is empty or being emptied.
   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

[rtl/core/soft_power_switch_fsm.sv]
// Top level of the soft power switch: configuration registers and the pipeline.
// Depends on spsw_pkg, spsw_in_stage, spsw_fsm and spsw_out_stage.
//
//   Channel  Direction  Handshake        Carries
//   req_     in         valid / ready    one millisecond tick item
//   rsp_     out        valid / ready    power hold, LED level, mode
//   csr_     in         write enable     register index and write data
//
// One item is accepted per clock when the result side keeps up. An accepted
// item waits in the input register; the state machine then feeds its result
// into the result register, from which the result handshake is offered.
// The state advances only when an item moves from the input register into
// the result register, so stalls on the result side freeze it exactly.
// Reset is synchronous and active high; it returns the latch to boot, clears
// both pipeline valids and loads the register defaults.
module soft_power_switch_fsm (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_button_pressed,
   input  logic [spsw_pkg::INACT_W-1:0]     req_inactive_time_q8,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_power_hold,
   output logic [1:0]                       rsp_led_level,
   output logic [2:0]                       rsp_mode_code,
   input  logic                             csr_write_en,
   input  logic [spsw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [spsw_pkg::CFG_W-1:0]       csr_wdata
);

   spsw_pkg::cfg_type    cfg_ff;
   spsw_pkg::item_type   req_item;
   spsw_pkg::item_type   item;
   spsw_pkg::result_type result;
   spsw_pkg::result_type rsp_result;
   logic                 item_valid;
   logic                 out_free;
   logic                 advance;

   // Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.push_to_start       <= spsw_pkg::RST_PUSH_TO_START;
         cfg_ff.press_off_ms        <= spsw_pkg::RST_PRESS_OFF_MS;
         cfg_ff.inactive_off_s      <= spsw_pkg::RST_INACTIVE_OFF_S;
         cfg_ff.turn_on_delay_ticks <= spsw_pkg::RST_TURN_ON_DELAY;
      end else if (csr_write_en) begin
         case (csr_index)
            spsw_pkg::CSR_PUSH_TO_START:  cfg_ff.push_to_start       <= csr_wdata[0];
            spsw_pkg::CSR_PRESS_OFF_MS:   cfg_ff.press_off_ms        <= csr_wdata;
            spsw_pkg::CSR_INACTIVE_OFF_S: cfg_ff.inactive_off_s      <= csr_wdata;
            spsw_pkg::CSR_TURN_ON_DELAY:  cfg_ff.turn_on_delay_ticks <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_item.button_pressed   = req_button_pressed;
   assign req_item.inactive_time_q8 = req_inactive_time_q8;

   spsw_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .down_free  (out_free),
      .item_valid (item_valid),
      .item       (item)
   );

   // The held item is consumed, and the state stepped, when the result
   // register can take its result.
   assign advance = item_valid && out_free;

   spsw_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .cfg     (cfg_ff),
      .result  (result)
   );

   spsw_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .free       (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_power_hold = rsp_result.power_hold;
   assign rsp_led_level  = rsp_result.led_level;
   assign rsp_mode_code  = rsp_result.mode_code;

endmodule
